/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define CFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cfd_pkg.sv */
package cfd_pkg;

	localparam logic [7:0]  SOF_BYTE    = 8'h55;
	localparam logic [7:0]  CRC8_SEED   = 8'h77;
	localparam logic [7:0]  CRC8_POLY   = 8'h8c;
	localparam logic [15:0] CRC16_SEED  = 16'h3692;
	localparam logic [15:0] CRC16_POLY  = 16'h8408;
	localparam logic [7:0]  ACK_BIT     = 8'h80;
	localparam logic [1:0]  LEN_HI_MASK = 2'b11;
	localparam logic [9:0]  MIN_LEN     = 10'd13;
	localparam logic [9:0]  FIRST_POS   = 10'd4;
	localparam logic [9:0]  ATTR_POS    = 10'd8;
	localparam logic [9:0]  CSET_POS    = 10'd9;
	localparam logic [9:0]  CID_POS     = 10'd10;
	localparam logic [9:0]  PAY_POS     = 10'd11;

	localparam logic [7:0]  RST_CMD_SET = 8'd13;
	localparam logic [7:0]  RST_CMD_ID  = 8'd2;
	localparam logic [9:0]  RST_MAX_PAY = 10'd64;

	typedef enum logic [1:0] {
		CFG_CMD_SET,
		CFG_CMD_ID,
		CFG_MAX_PAY
	} cfg_idx_t;

	typedef enum logic {
		PH_HUNT,
		PH_FRAME
	} phase_t;

	typedef struct packed {
		logic [7:0] want_cmd_set;
		logic [7:0] want_cmd_id;
		logic [9:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [9:0] byte_index;
		logic       is_end;
		logic       frame_good;
		logic [9:0] payload_length;
	} result_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] r;
		r = c ^ b;
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC8_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// partial crcs of a window of zero bytes
	localparam logic [7:0]  CRC8_Z1  = crc8_step(CRC8_SEED, 8'h00);
	localparam logic [7:0]  CRC8_Z2  = crc8_step(CRC8_Z1, 8'h00);
	localparam logic [7:0]  CRC8_Z3  = crc8_step(CRC8_Z2, 8'h00);
	localparam logic [15:0] CRC16_Z1 = crc16_step(CRC16_SEED, 8'h00);
	localparam logic [15:0] CRC16_Z2 = crc16_step(CRC16_Z1, 8'h00);
	localparam logic [15:0] CRC16_Z3 = crc16_step(CRC16_Z2, 8'h00);

endpackage

/* rtl/cfd_front.sv */
`include "assert_macros.svh"

module cfd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       rx_byte,
	input  cfd_pkg::cfg_t    cfg,
	output logic             res_valid,
	output cfd_pkg::result_t res
);

	cfd_pkg::phase_t phase_q, phase_d;

	logic [23:0] window_q;
	logic [7:0]  c8a_q, c8b_q, c8c_q;
	logic [15:0] c16a_q, c16b_q, c16c_q;
	logic [9:0]  len_q, pos_q;
	logic [15:0] crc_q;
	logic [7:0]  attr_q, cset_q, crc_lo_q;
	logic        match_q;

	logic [7:0]  b0, b1, b2;
	logic [9:0]  hdr_len;
	logic        hdr_hit;
	logic [10:0] pos_p2, len_ext;
	logic        body, crc_lo_pos, last;
	logic [9:0]  idx, pn_raw, pn;
	logic        pay_hit, good;

	assign b0      = window_q[23:16];
	assign b1      = window_q[15:8];
	assign b2      = window_q[7:0];
	assign hdr_len = {b2[1:0] & cfd_pkg::LEN_HI_MASK, b1};
	assign hdr_hit = (b0 == cfd_pkg::SOF_BYTE) && (hdr_len >= cfd_pkg::MIN_LEN)
		&& (c8c_q == rx_byte);

	assign pos_p2     = {1'b0, pos_q} + 11'd2;
	assign len_ext    = {1'b0, len_q};
	assign body       = pos_p2 < len_ext;
	assign crc_lo_pos = pos_p2 == len_ext;
	assign last       = !body && !crc_lo_pos;

	assign idx     = pos_q - cfd_pkg::PAY_POS;
	assign pay_hit = body && (pos_q >= cfd_pkg::PAY_POS) && match_q && (idx < cfg.max_payload);
	assign pn_raw  = len_q - cfd_pkg::MIN_LEN;
	assign pn      = (pn_raw > cfg.max_payload) ? cfg.max_payload : pn_raw;
	assign good    = (crc_q[7:0] == crc_lo_q) && (crc_q[15:8] == rx_byte);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			cfd_pkg::PH_HUNT: begin
				if (in_valid && hdr_hit) begin
					phase_d = cfd_pkg::PH_FRAME;
				end
			end
			cfd_pkg::PH_FRAME: begin
				if (in_valid && last) begin
					phase_d = cfd_pkg::PH_HUNT;
				end
			end
			default: phase_d = cfd_pkg::PH_HUNT;
		endcase
	end

	// result beat
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			cfd_pkg::PH_FRAME: begin
				if (in_valid && pay_hit) begin
					res_valid        = 1'b1;
					res.payload_byte = rx_byte;
					res.byte_index   = idx;
				end else if (in_valid && last && match_q) begin
					res_valid          = 1'b1;
					res.is_end         = 1'b1;
					res.frame_good     = good;
					res.payload_length = pn;
				end
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfd_pkg::PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			c8a_q    <= cfd_pkg::CRC8_Z1;
			c8b_q    <= cfd_pkg::CRC8_Z2;
			c8c_q    <= cfd_pkg::CRC8_Z3;
			c16a_q   <= cfd_pkg::CRC16_Z1;
			c16b_q   <= cfd_pkg::CRC16_Z2;
			c16c_q   <= cfd_pkg::CRC16_Z3;
			len_q    <= '0;
			pos_q    <= '0;
			crc_q    <= '0;
			attr_q   <= '0;
			cset_q   <= '0;
			crc_lo_q <= '0;
			match_q  <= 1'b0;
		end else if (in_valid) begin
			case (phase_q)
				cfd_pkg::PH_HUNT: begin
					if (hdr_hit) begin
						crc_q    <= cfd_pkg::crc16_step(c16c_q, rx_byte);
						len_q    <= hdr_len;
						pos_q    <= cfd_pkg::FIRST_POS;
						match_q  <= 1'b0;
						attr_q   <= '0;
						cset_q   <= '0;
						crc_lo_q <= '0;
						window_q <= '0;
						c8a_q    <= cfd_pkg::CRC8_Z1;
						c8b_q    <= cfd_pkg::CRC8_Z2;
						c8c_q    <= cfd_pkg::CRC8_Z3;
						c16a_q   <= cfd_pkg::CRC16_Z1;
						c16b_q   <= cfd_pkg::CRC16_Z2;
						c16c_q   <= cfd_pkg::CRC16_Z3;
					end else begin
						window_q <= {window_q[15:0], rx_byte};
						c8a_q    <= cfd_pkg::crc8_step(cfd_pkg::CRC8_SEED, rx_byte);
						c8b_q    <= cfd_pkg::crc8_step(c8a_q, rx_byte);
						c8c_q    <= cfd_pkg::crc8_step(c8b_q, rx_byte);
						c16a_q   <= cfd_pkg::crc16_step(cfd_pkg::CRC16_SEED, rx_byte);
						c16b_q   <= cfd_pkg::crc16_step(c16a_q, rx_byte);
						c16c_q   <= cfd_pkg::crc16_step(c16b_q, rx_byte);
					end
				end
				cfd_pkg::PH_FRAME: begin
					if (body) begin
						pos_q <= pos_q + 10'd1;
						crc_q <= cfd_pkg::crc16_step(crc_q, rx_byte);
						if (pos_q == cfd_pkg::ATTR_POS) begin
							attr_q <= rx_byte;
						end else if (pos_q == cfd_pkg::CSET_POS) begin
							cset_q <= rx_byte;
						end else if (pos_q == cfd_pkg::CID_POS) begin
							match_q <= ((attr_q & cfd_pkg::ACK_BIT) != 8'h00)
								&& (cset_q == cfg.want_cmd_set)
								&& (rx_byte == cfg.want_cmd_id);
						end
					end else if (crc_lo_pos) begin
						pos_q    <= pos_q + 10'd1;
						crc_lo_q <= rx_byte;
					end else begin
						pos_q    <= '0;
						match_q  <= 1'b0;
						window_q <= '0;
						c8a_q    <= cfd_pkg::CRC8_Z1;
						c8b_q    <= cfd_pkg::CRC8_Z2;
						c8c_q    <= cfd_pkg::CRC8_Z3;
						c16a_q   <= cfd_pkg::CRC16_Z1;
						c16b_q   <= cfd_pkg::CRC16_Z2;
						c16c_q   <= cfd_pkg::CRC16_Z3;
					end
				end
				default: pos_q <= pos_q;
			endcase
		end
	end

	`CFD_ASSERT_NXT(a_frame_end_rehunt, clk, arst_n, in_valid && (phase_q == cfd_pkg::PH_FRAME) && last, (phase_q == cfd_pkg::PH_HUNT) && (window_q == 24'h0), "frame end did not restart hunt")
	`CFD_ASSERT_IMP(a_payload_from_match, clk, arst_n, res_valid && !res.is_end, match_q && (phase_q == cfd_pkg::PH_FRAME) && (res.byte_index < cfg.max_payload), "payload beat outside a matching frame")

endmodule

/* rtl/cfd_queue.sv */
`include "assert_macros.svh"

module cfd_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  cfd_pkg::result_t wr_data,
	input  logic             rd_en,
	output cfd_pkg::result_t rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cfd_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign empty   = count_q == '0;
	assign full    = count_q == CW'(DEPTH);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`CFD_ASSERT_IMP(a_no_overflow, clk, arst_n, wr_en, !full, "result written into a full queue")
	`CFD_ASSERT_NXT(a_pop_drains, clk, arst_n, do_rd && !do_wr, count_q == $past(count_q) - CW'(1), "count did not drop on pop")

endmodule

/* rtl/crc_checked_frame_deframer_top.sv */
// Frame deframer: takes one received byte per push beat and hunts for a header (0x55, a 10-bit
// length of at least 13, a matching CRC-8), then checks the CRC-16 of the whole frame; for a
// response with the ack bit and the configured command set and id it pops out the payload bytes,
// clipped to max_payload, and a closing verdict beat carrying the CRC result. A byte is taken
// every cycle while not full; the header CRC-8 and CRC-16 prefixes are kept as running partials
// over the three-byte window so each byte needs one table step. A result reaches the pop side in
// the cycle after its byte is pushed. full rises only when the QUEUE_DEPTH-entry result queue is
// full, so bytes keep flowing while results wait to be popped. cfg_ready is always high.

module crc_checked_frame_deframer_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] payload_byte,
	output logic [9:0] byte_index,
	output logic       is_end,
	output logic       frame_good,
	output logic [9:0] payload_length,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	cfd_pkg::cfg_t    cfg_q;
	cfd_pkg::result_t res, head;
	logic             res_valid;
	logic             in_accept;

	assign cfg_ready = 1'b1;
	assign in_accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.want_cmd_set <= cfd_pkg::RST_CMD_SET;
			cfg_q.want_cmd_id  <= cfd_pkg::RST_CMD_ID;
			cfg_q.max_payload  <= cfd_pkg::RST_MAX_PAY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cfd_pkg::CFG_CMD_SET: cfg_q.want_cmd_set <= cfg_data[7:0];
				cfd_pkg::CFG_CMD_ID:  cfg_q.want_cmd_id  <= cfg_data[7:0];
				cfd_pkg::CFG_MAX_PAY: cfg_q.max_payload  <= cfg_data;
				default:              cfg_q <= cfg_q;
			endcase
		end
	end

	cfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_accept),
		.rx_byte   (rx_byte),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	cfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	assign payload_byte   = head.payload_byte;
	assign byte_index     = head.byte_index;
	assign is_end         = head.is_end;
	assign frame_good     = head.frame_good;
	assign payload_length = head.payload_length;

endmodule

/* sim/deframe_checker.sv */
`timescale 1ns / 1ps

module deframe_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] rx_byte,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] payload_byte,
	input  logic [9:0] byte_index,
	input  logic       is_end,
	input  logic       frame_good,
	input  logic [9:0] payload_length,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	output int         fail_count,
	output int         beats_owed
);

	cfd_pkg::result_t owed_beats[$];

	logic [7:0] want_set;
	logic [7:0] want_id;
	logic [9:0] max_pay;

	logic [23:0]     scan_win;
	cfd_pkg::phase_t frm_phase;
	logic [9:0]      frm_len;
	logic [9:0]      frm_pos;
	logic [15:0]     frm_crc;
	logic [7:0]      frm_attr;
	logic [7:0]      frm_cset;
	logic            frm_match;
	logic [7:0]      frm_crc_lo;

	function automatic logic [7:0] crc8_fold(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] x;
		x = c ^ b;
		repeat (8) x = (x >> 1) ^ (x[0] ? cfd_pkg::CRC8_POLY : 8'h00);
		return x;
	endfunction

	function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		repeat (8) x = (x >> 1) ^ (x[0] ? cfd_pkg::CRC16_POLY : 16'h0000);
		return x;
	endfunction

	task automatic clear_state();
		want_set   = cfd_pkg::RST_CMD_SET;
		want_id    = cfd_pkg::RST_CMD_ID;
		max_pay    = cfd_pkg::RST_MAX_PAY;
		scan_win   = '0;
		frm_phase  = cfd_pkg::PH_HUNT;
		frm_len    = '0;
		frm_pos    = '0;
		frm_crc    = '0;
		frm_attr   = '0;
		frm_cset   = '0;
		frm_match  = 1'b0;
		frm_crc_lo = '0;
		owed_beats.delete();
		fail_count = 0;
	endtask

	task automatic apply_reg(input logic [1:0] idx, input logic [9:0] val);
		case (cfd_pkg::cfg_idx_t'(idx))
			cfd_pkg::CFG_CMD_SET: want_set = val[7:0];
			cfd_pkg::CFG_CMD_ID:  want_id  = val[7:0];
			cfd_pkg::CFG_MAX_PAY: max_pay  = val;
			default: ;
		endcase
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0]       h0, h1, h2, hdr_crc;
		logic [9:0]       hlen;
		int               p, l, pn;
		cfd_pkg::result_t r;
		if (frm_phase == cfd_pkg::PH_HUNT) begin
			h0 = scan_win[23:16];
			h1 = scan_win[15:8];
			h2 = scan_win[7:0];
			hlen = {h2[1:0] & cfd_pkg::LEN_HI_MASK, h1};
			hdr_crc = crc8_fold(crc8_fold(crc8_fold(cfd_pkg::CRC8_SEED, h0), h1), h2);
			if (h0 == cfd_pkg::SOF_BYTE && hlen >= cfd_pkg::MIN_LEN && hdr_crc == b) begin
				frm_crc    = crc16_fold(crc16_fold(cfd_pkg::CRC16_SEED, h0), h1);
				frm_crc    = crc16_fold(crc16_fold(frm_crc, h2), b);
				frm_phase  = cfd_pkg::PH_FRAME;
				frm_len    = hlen;
				frm_pos    = cfd_pkg::FIRST_POS;
				frm_match  = 1'b0;
				frm_attr   = '0;
				frm_cset   = '0;
				frm_crc_lo = '0;
				scan_win   = '0;
			end else begin
				scan_win = {scan_win[15:0], b};
			end
			return;
		end
		p = int'(frm_pos);
		l = int'(frm_len);
		frm_pos = frm_pos + 10'd1;
		if (p + 2 < l) begin
			frm_crc = crc16_fold(frm_crc, b);
			if (p == int'(cfd_pkg::ATTR_POS)) begin
				frm_attr = b;
			end else if (p == int'(cfd_pkg::CSET_POS)) begin
				frm_cset = b;
			end else if (p == int'(cfd_pkg::CID_POS)) begin
				frm_match = (frm_attr & cfd_pkg::ACK_BIT) != 8'h00 && frm_cset == want_set
					&& b == want_id;
			end else if (p >= int'(cfd_pkg::PAY_POS) && frm_match
					&& p - int'(cfd_pkg::PAY_POS) < int'(max_pay)) begin
				r = '0;
				r.payload_byte = b;
				r.byte_index   = 10'(p - int'(cfd_pkg::PAY_POS));
				owed_beats.push_back(r);
			end
		end else if (p + 2 == l) begin
			frm_crc_lo = b;
		end else begin
			frm_phase = cfd_pkg::PH_HUNT;
			scan_win  = '0;
			frm_pos   = '0;
			if (frm_match) begin
				pn = l - int'(cfd_pkg::MIN_LEN);
				if (pn > int'(max_pay))
					pn = int'(max_pay);
				r = '0;
				r.is_end         = 1'b1;
				r.frame_good     = frm_crc[7:0] == frm_crc_lo && frm_crc[15:8] == b;
				r.payload_length = 10'(pn);
				owed_beats.push_back(r);
				frm_match = 1'b0;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_beat();
		cfd_pkg::result_t e;
		if (owed_beats.size() == 0) begin
			$error("result beat with nothing expected");
			fail_count++;
			return;
		end
		e = owed_beats.pop_front();
		check_field("payload_byte", {2'b00, e.payload_byte}, {2'b00, payload_byte});
		check_field("byte_index", e.byte_index, byte_index);
		check_field("is_end", {9'd0, e.is_end}, {9'd0, is_end});
		check_field("frame_good", {9'd0, e.frame_good}, {9'd0, frame_good});
		check_field("payload_length", e.payload_length, payload_length);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (pop && !empty)
				check_beat();
			if (push && !full)
				deframe_byte(rx_byte);
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
		end
		beats_owed = owed_beats.size();
	end

endmodule

/* sim/tb_crc_checked_frame_deframer_top.sv */
`timescale 1ns / 1ps

module tb_crc_checked_frame_deframer_top;

	localparam int         STALL_LEN = 300;
	localparam int         ITEMS     = 1350;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       pop       = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [9:0] cfg_data  = 10'd0;

	logic       full;
	logic       empty;
	logic [7:0] payload_byte;
	logic [9:0] byte_index;
	logic       is_end;
	logic       frame_good;
	logic [9:0] payload_length;
	logic       cfg_ready;

	int         fail_count;
	int         beats_owed;

	logic [7:0] tx_bytes[$];
	int         bytes_sent   = 0;
	bit         send_idle    = 1'b1;
	bit         recv_idle    = 1'b1;
	bit         stall_req    = 1'b0;
	int         stall_cycles = 0;

	logic [7:0] cur_set = cfd_pkg::RST_CMD_SET;
	logic [7:0] cur_id  = cfd_pkg::RST_CMD_ID;

	crc_checked_frame_deframer_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.rx_byte        (rx_byte),
		.empty          (empty),
		.pop            (pop),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.is_end         (is_end),
		.frame_good     (frame_good),
		.payload_length (payload_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	deframe_checker i_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.rx_byte        (rx_byte),
		.empty          (empty),
		.pop            (pop),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.is_end         (is_end),
		.frame_good     (frame_good),
		.payload_length (payload_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.beats_owed     (beats_owed)
	);

	always #2 clk = ~clk;

	// byte beats: hold while full, else take the next queued byte or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!(push && full)) begin
			if (push)
				void'(tx_bytes.pop_front());
			if (tx_bytes.size() != 0 && !(send_idle && $urandom_range(99) < 33)) begin
				push    <= 1'b1;
				rx_byte <= tx_bytes[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop          <= 1'b0;
			stall_cycles <= 0;
		end else if (stall_req && stall_cycles < STALL_LEN) begin
			pop          <= 1'b0;
			stall_cycles <= stall_cycles + 1;
		end else begin
			pop <= !(recv_idle && $urandom_range(99) < 33);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			cfd_pkg::CFG_CMD_SET: cur_set = val[7:0];
			cfd_pkg::CFG_CMD_ID:  cur_id  = val[7:0];
			default: ;
		endcase
	endtask

	task automatic queue_frame(input int len, input logic [7:0] attr, input logic [7:0] cset,
			input logic [7:0] cid, input bit bad_hdr = 1'b0, input bit bad_crc = 1'b0,
			input int keep = -1);
		logic [7:0]  fr[$];
		logic [9:0]  lv;
		logic [5:0]  junk;
		logic [15:0] sum;
		int          n;
		lv   = 10'(len);
		junk = 6'($urandom_range(63));
		fr.push_back(cfd_pkg::SOF_BYTE);
		fr.push_back(lv[7:0]);
		fr.push_back({junk, lv[9:8]});
		fr.push_back(cfd_pkg::crc8_step(cfd_pkg::crc8_step(cfd_pkg::crc8_step(
			cfd_pkg::CRC8_SEED, fr[0]), fr[1]), fr[2]) ^ (bad_hdr ? 8'h01 : 8'h00));
		for (int i = 4; i < len - 2; i++) begin
			if (i == int'(cfd_pkg::ATTR_POS))
				fr.push_back(attr);
			else if (i == int'(cfd_pkg::CSET_POS))
				fr.push_back(cset);
			else if (i == int'(cfd_pkg::CID_POS))
				fr.push_back(cid);
			else
				fr.push_back(8'($urandom_range(255)));
		end
		sum = cfd_pkg::CRC16_SEED;
		foreach (fr[k])
			sum = cfd_pkg::crc16_step(sum, fr[k]);
		if (bad_crc)
			sum = sum ^ (16'h0001 << $urandom_range(15));
		fr.push_back(sum[7:0]);
		fr.push_back(sum[15:8]);
		n = (keep < 0 || keep > fr.size()) ? fr.size() : keep;
		@(negedge clk);
		for (int k = 0; k < n; k++)
			tx_bytes.push_back(fr[k]);
		bytes_sent += n;
	endtask

	task automatic queue_noise(input int n);
		@(negedge clk);
		repeat (n) begin
			tx_bytes.push_back(($urandom_range(7) == 0) ? cfd_pkg::SOF_BYTE
				: 8'($urandom_range(255)));
			bytes_sent++;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (tx_bytes.size() != 0 || push || beats_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int         len;
		int         keep;
		logic [7:0] a, s, d;
		logic [9:0] mx;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: empty payload, short payload, bad crc16, the three mismatches
		queue_frame(13, cfd_pkg::ACK_BIT, cur_set, cur_id);
		queue_frame(14, 8'hff, cur_set, cur_id);
		queue_frame(20, cfd_pkg::ACK_BIT, cur_set, cur_id, 1'b0, 1'b1);
		queue_frame(16, 8'h7f, cur_set, cur_id);
		queue_frame(16, cfd_pkg::ACK_BIT, ~cur_set, cur_id);
		queue_frame(16, cfd_pkg::ACK_BIT, cur_set, ~cur_id);
		// length below minimum, bad header crc, clipped payload, truncated frame
		queue_frame(12, cfd_pkg::ACK_BIT, cur_set, cur_id);
		queue_frame(18, cfd_pkg::ACK_BIT, cur_set, cur_id, 1'b1);
		queue_frame(83, cfd_pkg::ACK_BIT, cur_set, cur_id);
		queue_frame(30, cfd_pkg::ACK_BIT, cur_set, cur_id, 1'b0, 1'b0, 9);
		queue_frame(24, cfd_pkg::ACK_BIT, cur_set, cur_id);
		queue_noise(6);
		queue_frame(15, cfd_pkg::ACK_BIT, cur_set, cur_id);
		drain();

		write_reg(cfd_pkg::CFG_CMD_SET, 10'h3ff);
		write_reg(cfd_pkg::CFG_CMD_ID, 10'h000);
		write_reg(cfd_pkg::CFG_MAX_PAY, 10'd0);
		queue_frame(40, cfd_pkg::ACK_BIT, cur_set, cur_id);
		queue_frame(20, 8'hff, cur_set, cur_id, 1'b0, 1'b1);
		drain();

		write_reg(cfd_pkg::CFG_CMD_SET, 10'h100);
		write_reg(cfd_pkg::CFG_CMD_ID, 10'h2ff);
		write_reg(cfd_pkg::CFG_MAX_PAY, 10'd1023);
		queue_frame(150, cfd_pkg::ACK_BIT, cur_set, cur_id);
		drain();
		write_reg(cfd_pkg::CFG_MAX_PAY, 10'd1010);
		write_reg(CFG_SPARE, 10'h3ff);
		queue_frame(120, cfd_pkg::ACK_BIT, cur_set, cur_id);
		drain();
		write_reg(cfd_pkg::CFG_MAX_PAY, 10'd100);
		queue_frame(130, cfd_pkg::ACK_BIT, cur_set, cur_id, 1'b0, 1'b1);
		drain();

		// receiver holds off while a long frame keeps coming
		write_reg(cfd_pkg::CFG_MAX_PAY, 10'd1023);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		stall_req = 1'b1;
		queue_frame(150, cfd_pkg::ACK_BIT, cur_set, cur_id);
		drain();
		send_idle = 1'b1;
		recv_idle = 1'b1;

		for (int ph = 0; bytes_sent < ITEMS; ph++) begin
			write_reg(cfd_pkg::CFG_CMD_SET, 10'($urandom_range(1023)));
			write_reg(cfd_pkg::CFG_CMD_ID, 10'($urandom_range(1023)));
			case ($urandom_range(9))
				0:       mx = 10'd0;
				1:       mx = 10'd1023;
				2:       mx = 10'd1010;
				3, 4:    mx = 10'($urandom_range(1023));
				default: mx = 10'($urandom_range(1, 12));
			endcase
			write_reg(cfd_pkg::CFG_MAX_PAY, mx);
			send_idle = !(ph == 1 || ph == 2);
			recv_idle = !(ph == 1 || ph == 2);
			repeat (5) begin
				if ($urandom_range(9) < 8)
					len = 13 + $urandom_range(20);
				else
					len = 13 + $urandom_range(21, 90);
				a = 8'($urandom_range(255));
				if ($urandom_range(4) != 0)
					a = a | cfd_pkg::ACK_BIT;
				s = cur_set;
				d = cur_id;
				if ($urandom_range(7) == 0)
					s = 8'($urandom_range(255));
				if ($urandom_range(7) == 0)
					d = 8'($urandom_range(255));
				keep = ($urandom_range(19) == 0) ? int'($urandom_range(4, len - 1)) : -1;
				queue_frame(len, a, s, d, $urandom_range(19) == 0, $urandom_range(6) == 0, keep);
				if ($urandom_range(1) != 0)
					queue_noise($urandom_range(1, 4));
			end
			drain();
		end

		repeat (8) @(negedge clk);
		if (fail_count == 0 && beats_owed == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
